### rtl/mfba_pkg.sv
// ----------------------------------------------------------------------------
// mfba_pkg
// Shared types and constants of the multi-frame bump allocator: function
// codes, register indexes, reset values and the controller/datapath links.
// ----------------------------------------------------------------------------
package mfba_pkg;

	// function codes of an input request
	localparam logic [1:0] FUNC_ALLOC   = 2'd0;
	localparam logic [1:0] FUNC_CLEAR   = 2'd1;
	localparam logic [1:0] FUNC_ADVANCE = 2'd2;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COUNT    = 2'd1;

	// configuration reset values
	localparam logic [31:0] CAPACITY_RESET = 32'd1048576;
	localparam logic [3:0]  COUNT_RESET    = 4'd3;

	// commands from the controller to the datapath
	typedef struct packed {
		logic latch;
		logic clear_cur;
		logic mod_init;
		logic mod_step;
		logic mod_commit;
		logic rd;
		logic align;
		logic check;
		logic load_out;
	} ctrl_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic [1:0] func;
		logic       mod_done;
	} ctrl_sts_t;

endpackage

### rtl/mfba_ram.sv
// ----------------------------------------------------------------------------
// mfba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mfba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/mfba_dpath.sv
// ----------------------------------------------------------------------------
// mfba_dpath
// Datapath of the bump allocator: configuration registers, current frame,
// ring modulo step, offset and peak memories with valid bits, align/check
// arithmetic and the result registers.
// ----------------------------------------------------------------------------
module mfba_dpath #(
	parameter int MAX_FRAMES  = 8,
	parameter int OFFSET_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration writes
	input  logic                          cfg_we,
	input  logic [mfba_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data,
	// request payload
	input  logic [1:0]                    func,
	input  logic [31:0]                   request_size,
	input  logic [3:0]                    align_log2,
	// controller link
	input  mfba_pkg::ctrl_cmd_t           cmd,
	output mfba_pkg::ctrl_sts_t           sts,
	// result payload
	output logic                          granted,
	output logic [31:0]                   grant_offset,
	output logic [2:0]                    frame_index,
	output logic [31:0]                   used_bytes,
	output logic [31:0]                   peak_bytes
);

	localparam int FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int RW = $clog2(MAX_FRAMES + 1);
	localparam int EW = ((OFFSET_BITS > 32) ? OFFSET_BITS : 32) + 2;
	localparam logic [EW-1:0] OFF_MAX = (EW'(1) << OFFSET_BITS) - EW'(1);
	localparam logic [EW-1:0] CAP_RST_W =
		(EW'(mfba_pkg::CAPACITY_RESET) > OFF_MAX) ? OFF_MAX : EW'(mfba_pkg::CAPACITY_RESET);

	// configuration and control state
	logic [OFFSET_BITS-1:0] cap_q;
	logic [3:0]             count_q;
	logic [FW-1:0]          cur_q;
	logic [RW-1:0]          ring_r_q;
	logic                   off_vld_q [MAX_FRAMES];
	logic                   pk_vld_q  [MAX_FRAMES];

	// request and working registers
	logic [1:0]             func_q;
	logic [31:0]            size_q;
	logic [3:0]             lg_q;
	logic                   off_rvld_q;
	logic                   pk_rvld_q;
	logic [OFFSET_BITS-1:0] off_cur_q;
	logic [OFFSET_BITS-1:0] peak_cur_q;
	logic [EW-1:0]          aligned_q;
	logic                   res_granted_q;
	logic [31:0]            res_start_q;
	logic [31:0]            res_used_q;
	logic [31:0]            res_peak_q;

	// combinational
	logic [RW-1:0]          ring_n;
	logic [OFFSET_BITS-1:0] off_rdata;
	logic [OFFSET_BITS-1:0] pk_rdata;
	logic [OFFSET_BITS-1:0] cur_off;
	logic [EW-1:0]          amask;
	logic [EW-1:0]          end_w;
	logic [EW-1:0]          cap_w;
	logic                   fit;
	logic                   ok;
	logic                   raise;
	logic [FW+2:0]          frame_ext;

	function automatic logic [31:0] to32(input logic [OFFSET_BITS-1:0] v);
		logic [OFFSET_BITS+31:0] e;
		e = {32'b0, v};
		return e[31:0];
	endfunction

	// ring size from frame_count, clamped to one .. MAX_FRAMES
	always_comb begin
		if (count_q == 4'd0) begin
			ring_n = RW'(1);
		end else if ({4'b0, count_q} > 8'(MAX_FRAMES)) begin
			ring_n = RW'(MAX_FRAMES);
		end else begin
			ring_n = RW'(count_q);
		end
	end

	assign sts.func     = func_q;
	assign sts.mod_done = (ring_r_q < ring_n);

	// capacity limited to what an offset can hold
	assign cap_w = (EW'(cfg_data) > OFF_MAX) ? OFF_MAX : EW'(cfg_data);

	// alignment and fit check
	assign cur_off = off_rvld_q ? off_rdata : '0;
	assign amask   = (EW'(1) << lg_q) - EW'(1);
	assign end_w   = aligned_q + EW'(size_q);
	assign fit     = (end_w <= EW'(cap_q));
	assign ok      = cmd.check && (func_q == mfba_pkg::FUNC_ALLOC) && fit;
	assign raise   = ok && (end_w > EW'(peak_cur_q));

	assign frame_ext = {3'b0, cur_q};

	// offset and peak memories, both read at the current frame
	mfba_ram #(.WIDTH(OFFSET_BITS), .DEPTH(MAX_FRAMES)) u_off_ram (
		.clk   (clk),
		.we    (ok),
		.waddr (cur_q),
		.wdata (end_w[OFFSET_BITS-1:0]),
		.re    (cmd.rd),
		.raddr (cur_q),
		.rdata (off_rdata)
	);

	mfba_ram #(.WIDTH(OFFSET_BITS), .DEPTH(MAX_FRAMES)) u_pk_ram (
		.clk   (clk),
		.we    (raise),
		.waddr (cur_q),
		.wdata (end_w[OFFSET_BITS-1:0]),
		.re    (cmd.rd),
		.raddr (cur_q),
		.rdata (pk_rdata)
	);

	// configuration, current frame and valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= CAP_RST_W[OFFSET_BITS-1:0];
			count_q  <= mfba_pkg::COUNT_RESET;
			cur_q    <= '0;
			ring_r_q <= '0;
			for (int i = 0; i < MAX_FRAMES; i++) begin
				off_vld_q[i] <= 1'b0;
				pk_vld_q[i]  <= 1'b0;
			end
		end else begin
			if (cfg_we && (cfg_index == mfba_pkg::CFG_CAPACITY)) begin
				cap_q <= cap_w[OFFSET_BITS-1:0];
			end
			if (cfg_we && (cfg_index == mfba_pkg::CFG_COUNT)) begin
				count_q <= cfg_data[3:0];
			end
			if (cmd.clear_cur) begin
				off_vld_q[cur_q] <= 1'b0;
			end
			if (cmd.mod_init) begin
				ring_r_q <= RW'(cur_q) + RW'(1);
			end
			if (cmd.mod_step) begin
				ring_r_q <= ring_r_q - ring_n;
			end
			if (cmd.mod_commit) begin
				cur_q                      <= ring_r_q[FW-1:0];
				off_vld_q[ring_r_q[FW-1:0]] <= 1'b0;
			end
			if (ok) begin
				off_vld_q[cur_q] <= 1'b1;
			end
			if (raise) begin
				pk_vld_q[cur_q] <= 1'b1;
			end
		end
	end

	// request, working and result registers
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			func_q <= func;
			size_q <= request_size;
			lg_q   <= align_log2;
		end
		if (cmd.rd) begin
			off_rvld_q <= off_vld_q[cur_q];
			pk_rvld_q  <= pk_vld_q[cur_q];
		end
		if (cmd.align) begin
			off_cur_q  <= cur_off;
			peak_cur_q <= pk_rvld_q ? pk_rdata : '0;
			aligned_q  <= (EW'(cur_off) + amask) & ~amask;
		end
		if (cmd.check) begin
			if (func_q == mfba_pkg::FUNC_ALLOC) begin
				res_granted_q <= fit;
			end else begin
				res_granted_q <= (func_q == mfba_pkg::FUNC_CLEAR) ||
				                 (func_q == mfba_pkg::FUNC_ADVANCE);
			end
			res_start_q <= ok ? to32(aligned_q[OFFSET_BITS-1:0]) : 32'd0;
			res_used_q  <= ok ? to32(end_w[OFFSET_BITS-1:0]) : to32(off_cur_q);
			res_peak_q  <= raise ? to32(end_w[OFFSET_BITS-1:0]) : to32(peak_cur_q);
		end
		if (cmd.load_out) begin
			granted      <= res_granted_q;
			grant_offset <= res_start_q;
			frame_index  <= frame_ext[2:0];
			used_bytes   <= res_used_q;
			peak_bytes   <= res_peak_q;
		end
	end

endmodule

### rtl/mfba_ctrl.sv
// ----------------------------------------------------------------------------
// mfba_ctrl
// Controller of the bump allocator: sequences one request through clear or
// ring step, memory read, align, check and result hand-off.
// ----------------------------------------------------------------------------
module mfba_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  mfba_pkg::ctrl_sts_t sts,
	output mfba_pkg::ctrl_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EXEC  = 3'd1;
	localparam logic [2:0] ST_MOD   = 3'd2;
	localparam logic [2:0] ST_READ  = 3'd3;
	localparam logic [2:0] ST_ALIGN = 3'd4;
	localparam logic [2:0] ST_CHECK = 3'd5;
	localparam logic [2:0] ST_RESP  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	// next state and commands
	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (sts.func == mfba_pkg::FUNC_ADVANCE) begin
					cmd.mod_init = 1'b1;
					state_d      = ST_MOD;
				end else begin
					cmd.clear_cur = (sts.func == mfba_pkg::FUNC_CLEAR);
					state_d       = ST_READ;
				end
			end
			ST_MOD: begin
				if (sts.mod_done) begin
					cmd.mod_commit = 1'b1;
					state_d        = ST_READ;
				end else begin
					cmd.mod_step = 1'b1;
				end
			end
			ST_READ: begin
				cmd.rd  = 1'b1;
				state_d = ST_ALIGN;
			end
			ST_ALIGN: begin
				cmd.align = 1'b1;
				state_d   = ST_CHECK;
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				state_d   = ST_RESP;
			end
			ST_RESP: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### rtl/multi_frame_bump_allocator_top.sv
// ----------------------------------------------------------------------------
// multi_frame_bump_allocator_top
// Bump allocator over a ring of frames, with per-frame offset and peak mark.
// ----------------------------------------------------------------------------
// The block takes one request at a time. An allocate, reset or unused-code
// request steps through latch, execute (clear of the current frame for a
// reset), read of the offset and peak memories, align, check and result load;
// an advance request adds k ring-size subtractions and a commit of the frame
// index modulo (k is 0 or 1 unless frame_count was lowered below the current
// frame). The result register frees the input side once loaded; a stalled
// result holds the next request in the result-load step. Configuration writes
// are always ready and must be issued only while the block is idle.
module multi_frame_bump_allocator_top #(
	parameter int MAX_FRAMES  = 8,
	parameter int OFFSET_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [mfba_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data,
	// request channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    func,
	input  logic [31:0]                   request_size,
	input  logic [3:0]                    align_log2,
	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          granted,
	output logic [31:0]                   grant_offset,
	output logic [2:0]                    frame_index,
	output logic [31:0]                   used_bytes,
	output logic [31:0]                   peak_bytes
);

	mfba_pkg::ctrl_cmd_t cmd;
	mfba_pkg::ctrl_sts_t sts;

	assign cfg_ready = 1'b1;

	// sequencing
	mfba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// storage and arithmetic
	mfba_dpath #(
		.MAX_FRAMES  (MAX_FRAMES),
		.OFFSET_BITS (OFFSET_BITS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.func         (func),
		.request_size (request_size),
		.align_log2   (align_log2),
		.cmd          (cmd),
		.sts          (sts),
		.granted      (granted),
		.grant_offset (grant_offset),
		.frame_index  (frame_index),
		.used_bytes   (used_bytes),
		.peak_bytes   (peak_bytes)
	);

endmodule

### rtl/mfba_checker.sv
// ----------------------------------------------------------------------------
// mfba_checker
// Port-level checks of the bump allocator, bound to the top level.
// ----------------------------------------------------------------------------
module mfba_checker #(
	parameter int MAX_FRAMES  = 8,
	parameter int OFFSET_BITS = 32
) (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic        granted,
	input logic [31:0] grant_offset,
	input logic [2:0]  frame_index,
	input logic [31:0] used_bytes,
	input logic [31:0] peak_bytes
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(grant_offset) &&
		$stable(used_bytes) && $stable(peak_bytes) && $stable(granted))
		else $error("stalled result changed");

	// one request in flight: the input side closes after an accepted request
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second request accepted while busy");

	// a refused request reports no offset
	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !granted |-> grant_offset == 32'd0)
		else $error("offset reported for refused request");

	// the peak mark never trails the current offset
	a_peak_ge_used: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (OFFSET_BITS <= 32) |-> used_bytes <= peak_bytes)
		else $error("peak below used bytes");

	// frame index stays below MAX_FRAMES (checked only when MAX_FRAMES is below 8)
	a_frame_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (MAX_FRAMES < 8) |-> 32'(frame_index) < 32'(MAX_FRAMES))
		else $error("frame index beyond ring");

endmodule

bind multi_frame_bump_allocator_top mfba_checker #(
	.MAX_FRAMES  (MAX_FRAMES),
	.OFFSET_BITS (OFFSET_BITS)
) u_mfba_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.granted      (granted),
	.grant_offset (grant_offset),
	.frame_index  (frame_index),
	.used_bytes   (used_bytes),
	.peak_bytes   (peak_bytes)
);
